// ===== hdl/scld_pkg.sv =====
// shared types, constants and event codes for the serial command line decoder
// no dependencies
package scld_pkg;

  // line geometry
  localparam int LINE_CHARS = 31;
  localparam int MAX_DIGITS = 15;
  localparam int CNT_W      = $clog2(LINE_CHARS + 1);
  localparam int DIG_W      = $clog2(MAX_DIGITS + 1);

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // event codes
  localparam logic [3:0] EV_SERVO_OK   = 4'd0;
  localparam logic [3:0] EV_SERVO_BUSY = 4'd1;
  localparam logic [3:0] EV_AUDIO_OK   = 4'd2;
  localparam logic [3:0] EV_AUDIO_BUSY = 4'd3;
  localparam logic [3:0] EV_PROMPT     = 4'd4;
  localparam logic [3:0] EV_LDO        = 4'd5;
  localparam logic [3:0] EV_LASER      = 4'd6;
  localparam logic [3:0] EV_FAN        = 4'd7;
  localparam logic [3:0] EV_POS_OK     = 4'd8;
  localparam logic [3:0] EV_POS_BUSY   = 4'd9;
  localparam logic [3:0] EV_INVALID    = 4'd10;
  localparam logic [3:0] EV_TOO_LONG   = 4'd11;
  localparam logic [3:0] EV_IGNORED    = 4'd12;

  // input transaction
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       servo_busy;
    logic       audio_busy;
    logic       position_busy;
  } rx_item_t;

  // result transaction
  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] position;
    logic       ldo_level;
    logic       laser_level;
    logic       fan_level;
  } res_item_t;

endpackage

// ===== hdl/serial_command_line_decoder.sv =====
// serial command line decoder: input register, line decode, result register
// each byte is held in the input register, and its result is loaded into the result register
// throughput: one byte per cycle while the result side is not stalled
// bytes that end nothing produce no result transaction
// reset (rst, synchronous): empty line, menu mode, ldo and laser off, fan flag set
// depends on scld_pkg, scld_line_proc, scld_out_reg
module serial_command_line_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  scld_pkg::rx_item_t  rx_item,
  output logic                res_valid,
  input  logic                res_stall,
  output scld_pkg::res_item_t res_item
);
  import scld_pkg::*;

  logic      in_full, in_full_next;
  rx_item_t  in_data;
  logic      accept;
  logic      advance;
  logic      out_free;
  logic      has_res;
  res_item_t line_res;

  // input register handshake
  assign advance  = in_full && out_free;
  assign rx_stall = in_full && !out_free;
  assign accept   = rx_valid && !rx_stall;

  always_comb begin
    in_full_next = in_full;
    if (accept) begin
      in_full_next = 1'b1;
    end else if (advance) begin
      in_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data <= rx_item;
    end
  end

  // line state and decode
  scld_line_proc u_line (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .item    (in_data),
    .has_res (has_res),
    .res     (line_res)
  );

  // result register
  scld_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_res),
    .din       (line_res),
    .free      (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== hdl/scld_line_proc.sv =====
// line assembly state and command decode for one received byte
// depends on scld_pkg
module scld_line_proc (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  scld_pkg::rx_item_t  item,
  output logic                has_res,
  output scld_pkg::res_item_t res
);
  import scld_pkg::*;

  logic [CNT_W-1:0] char_count, char_count_next;
  logic [CNT_W-1:0] visible_length, visible_length_next;
  logic [7:0]       first_char, first_char_next;
  logic [DIG_W-1:0] digit_count, digit_count_next;
  logic [7:0]       digit_value, digit_value_next;
  logic             numeric_mode, numeric_mode_next;
  logic             ldo_on, ldo_on_next;
  logic             laser_en, laser_en_next;
  logic             fan_flag, fan_flag_next;

  logic [7:0]       c;
  logic             is_eol;
  logic             is_digit;
  logic [CNT_W-1:0] vl_base;
  logic [DIG_W-1:0] dc_base;
  logic [7:0]       dv_base;
  logic [3:0]       ev;
  logic [7:0]       pos;

  assign c        = item.rx_byte;
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // a new line starts from cleared counters
  assign vl_base = (char_count == '0) ? '0 : visible_length;
  assign dc_base = (char_count == '0) ? '0 : digit_count;
  assign dv_base = (char_count == '0) ? 8'd0 : digit_value;

  // next state and result for the byte
  always_comb begin
    char_count_next     = char_count;
    visible_length_next = visible_length;
    first_char_next     = first_char;
    digit_count_next    = digit_count;
    digit_value_next    = digit_value;
    numeric_mode_next   = numeric_mode;
    ldo_on_next         = ldo_on;
    laser_en_next       = laser_en;
    fan_flag_next       = fan_flag;
    has_res             = 1'b0;
    ev                  = EV_IGNORED;
    pos                 = 8'd0;
    if (is_eol) begin
      if (char_count != '0) begin
        char_count_next = '0;
        has_res         = 1'b1;
        if (numeric_mode) begin
          numeric_mode_next = 1'b0;
          if (digit_count == '0) begin
            ev = EV_INVALID;
          end else begin
            ev  = item.position_busy ? EV_POS_BUSY : EV_POS_OK;
            pos = digit_value;
          end
        end else if (visible_length != CNT_W'(1)) begin
          ev = EV_IGNORED;
        end else begin
          unique case (first_char)
            CH_ONE:   ev = item.servo_busy ? EV_SERVO_BUSY : EV_SERVO_OK;
            CH_TWO:   ev = item.audio_busy ? EV_AUDIO_BUSY : EV_AUDIO_OK;
            CH_THREE: begin
              numeric_mode_next = 1'b1;
              ev                = EV_PROMPT;
            end
            CH_FOUR: begin
              ldo_on_next = ~ldo_on;
              ev          = EV_LDO;
            end
            CH_FIVE: begin
              laser_en_next = ~laser_en;
              ev            = EV_LASER;
            end
            CH_NINE: begin
              fan_flag_next = ~fan_flag;
              ev            = EV_FAN;
            end
            default: ev = EV_IGNORED;
          endcase
        end
      end
    end else if (char_count >= CNT_W'(LINE_CHARS)) begin
      char_count_next = '0;
      has_res         = 1'b1;
      ev              = EV_TOO_LONG;
    end else begin
      visible_length_next = vl_base;
      digit_count_next    = dc_base;
      digit_value_next    = dv_base;
      if (char_count == '0) begin
        first_char_next = c;
      end
      // only bytes before the first zero byte are visible
      if ((vl_base == char_count) && (c != CH_NUL)) begin
        visible_length_next = vl_base + CNT_W'(1);
        if (is_digit && (dc_base < DIG_W'(MAX_DIGITS))) begin
          digit_value_next = (dv_base << 3) + (dv_base << 1) + (c - CH_ZERO);
          digit_count_next = dc_base + DIG_W'(1);
        end
      end
      char_count_next = char_count + CNT_W'(1);
    end
  end

  // result fields carry levels after the update
  always_comb begin
    res.event_res   = ev;
    res.position    = pos;
    res.ldo_level   = ldo_on_next;
    res.laser_level = laser_en_next;
    res.fan_level   = ~fan_flag_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count     <= '0;
      visible_length <= '0;
      first_char     <= 8'd0;
      digit_count    <= '0;
      digit_value    <= 8'd0;
      numeric_mode   <= 1'b0;
      ldo_on         <= 1'b0;
      laser_en       <= 1'b0;
      fan_flag       <= 1'b1;
    end else if (take) begin
      char_count     <= char_count_next;
      visible_length <= visible_length_next;
      first_char     <= first_char_next;
      digit_count    <= digit_count_next;
      digit_value    <= digit_value_next;
      numeric_mode   <= numeric_mode_next;
      ldo_on         <= ldo_on_next;
      laser_en       <= laser_en_next;
      fan_flag       <= fan_flag_next;
    end
  end

endmodule

// ===== hdl/scld_out_reg.sv =====
// result register holding one transaction until the consumer takes it
// depends on scld_pkg
module scld_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  scld_pkg::res_item_t din,
  output logic                free,
  output logic                res_valid,
  input  logic                res_stall,
  output scld_pkg::res_item_t res_item
);
  import scld_pkg::*;

  logic      full, full_next;
  res_item_t data;

  // slot is free when empty or being drained this cycle
  assign free = !full || !res_stall;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (!res_stall) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

  assign res_valid = full;
  assign res_item  = data;

endmodule

// ===== tb/sv/serial_command_line_decoder_tb.sv =====
// self-checking testbench for serial_command_line_decoder
// depends on scld_pkg and the decoder rtl; predicts each event from its own line decoder
`timescale 1ns / 1ps

module serial_command_line_decoder_tb;
  import scld_pkg::*;

  localparam int RANDOM_BYTES = 1200;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_stall;
  rx_item_t  rx_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  serial_command_line_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #6 clk = ~clk;

  // line decoder state, mirrors the block after each accepted byte
  logic [CNT_W-1:0] line_len  = '0;
  logic [CNT_W-1:0] vis_len   = '0;
  logic [7:0]       first_ch  = '0;
  logic [DIG_W-1:0] dig_cnt   = '0;
  logic [7:0]       dig_val   = '0;
  logic             num_mode  = 1'b0;
  logic             ldo_state = 1'b0;
  logic             laser_state = 1'b0;
  logic             fan_flag  = 1'b1;

  res_item_t  pending_events[$];
  logic [7:0] line_buf[$];

  int  mismatch_count  = 0;
  int  bytes_sent      = 0;
  int  events_checked  = 0;
  int  idle_cycles     = 0;
  bit  ev_seen[16];
  bit  sender_gaps_on  = 1'b1;
  bit  receiver_stalls_on = 1'b1;
  bit  hold_request    = 1'b0;

  // advance the line decoder by one byte; returns 1 when the byte produces an event
  function automatic bit decode_byte(input rx_item_t it, output res_item_t ev);
    logic [7:0] c;
    logic [3:0] code;
    logic [7:0] pos;
    bit         produced;
    c = it.rx_byte;
    code = EV_IGNORED;
    pos = '0;
    produced = 1'b0;
    if (c == CH_CR || c == CH_LF) begin
      if (line_len != 0) begin
        line_len = '0;
        produced = 1'b1;
        if (num_mode) begin
          num_mode = 1'b0;
          if (dig_cnt == 0) begin
            code = EV_INVALID;
          end else begin
            code = it.position_busy ? EV_POS_BUSY : EV_POS_OK;
            pos = dig_val;
          end
        end else if (vis_len != 1) begin
          code = EV_IGNORED;
        end else begin
          case (first_ch)
            CH_ONE:   code = it.servo_busy ? EV_SERVO_BUSY : EV_SERVO_OK;
            CH_TWO:   code = it.audio_busy ? EV_AUDIO_BUSY : EV_AUDIO_OK;
            CH_THREE: begin
              num_mode = 1'b1;
              code = EV_PROMPT;
            end
            CH_FOUR: begin
              ldo_state = ~ldo_state;
              code = EV_LDO;
            end
            CH_FIVE: begin
              laser_state = ~laser_state;
              code = EV_LASER;
            end
            CH_NINE: begin
              fan_flag = ~fan_flag;
              code = EV_FAN;
            end
            default:  code = EV_IGNORED;
          endcase
        end
      end
    end else if (line_len >= LINE_CHARS) begin
      // overlong line: byte dropped, line emptied, mode kept
      line_len = '0;
      produced = 1'b1;
      code = EV_TOO_LONG;
    end else begin
      if (line_len == 0) begin
        vis_len = '0;
        first_ch = c;
        dig_cnt = '0;
        dig_val = '0;
      end
      // a zero byte hides itself and the rest of the line
      if (vis_len == line_len && c != CH_NUL) begin
        vis_len = vis_len + 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE && dig_cnt < MAX_DIGITS) begin
          dig_val = 8'(dig_val * 10 + (c - CH_ZERO));
          dig_cnt = dig_cnt + 1'b1;
        end
      end
      line_len = line_len + 1'b1;
    end
    ev.event_res   = code;
    ev.position    = pos;
    ev.ldo_level   = ldo_state;
    ev.laser_level = laser_state;
    ev.fan_level   = ~fan_flag;
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // send one byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] c, input logic sb, input logic ab,
                           input logic pb);
    int        gap;
    rx_item_t  it;
    res_item_t ev;
    gap = sender_gaps_on ? $urandom_range(0, 11) : 0;
    it.rx_byte = c;
    it.servo_busy = sb;
    it.audio_busy = ab;
    it.position_busy = pb;
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_item <= it;
    do @(posedge clk); while (rx_stall !== 1'b0);
    if (decode_byte(it, ev)) pending_events.push_back(ev);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_eol();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // mostly real commands, now and then any digit from 0 to 9
  function automatic logic [7:0] menu_char();
    logic [7:0] cmds[6];
    cmds = '{CH_ONE, CH_TWO, CH_THREE, CH_FOUR, CH_FIVE, CH_NINE};
    if ($urandom_range(0, 7) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
    return cmds[$urandom_range(0, 5)];
  endfunction

  // menu commands other than three, both servo busy outcomes, zero byte, unknown and empty lines
  task automatic test_menu_commands();
    send_byte(CH_ONE, 1'b0, 1'b1, 1'b1);
    send_byte(CH_CR, 1'b0, 1'b1, 1'b1);
    send_byte(CH_ONE, 1'b1, 1'b0, 1'b0);
    send_byte(CH_NUL, 1'b1, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b1, 1'b0, 1'b0);
    send_byte(CH_TWO, 1'b0, 1'b1, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b1, 1'b0);
    send_byte(CH_FOUR, 1'b0, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0, 1'b0);
    send_byte(CH_FIVE, 1'b1, 1'b1, 1'b1);
    send_byte(CH_CR, 1'b1, 1'b1, 1'b1);
    send_byte(CH_NINE, 1'b0, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1, 1'b1);
    send_byte(CH_CR, 1'b1, 1'b1, 1'b1);
    send_byte(CH_LF, 1'b0, 1'b0, 1'b0);
  endtask

  // numeric mode: wrap modulo 256 with position busy, empty line, line without digits
  task automatic test_numeric_entry();
    send_byte(CH_THREE, 1'b0, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0, 1'b0);
    send_byte(CH_TWO, 1'b0, 1'b0, 1'b1);
    send_byte(8'h35, 1'b0, 1'b0, 1'b1);
    send_byte(8'h36, 1'b0, 1'b0, 1'b1);
    send_byte(CH_LF, 1'b0, 1'b0, 1'b1);
    send_byte(CH_THREE, 1'b0, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0, 1'b0);
    send_byte(8'h78, 1'b0, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0, 1'b0);
  endtask

  // random lines: commands, number entries, long lines, zero bytes and noise
  task automatic test_random_traffic();
    int kind;
    int len;
    int start;
    int mode;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 47) == 0) begin
        mode = $urandom_range(0, 3);
        sender_gaps_on = mode[0];
        receiver_stalls_on = mode[1];
      end
      line_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        line_buf.push_back(menu_char());
      end else if (kind < 60) begin
        // number entry, sometimes past the digit limit or without digits
        line_buf.push_back(CH_THREE);
        line_buf.push_back(random_eol());
        len = $urandom_range(1, 20);
        repeat (len) begin
          if ($urandom_range(0, 9) != 0) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          else line_buf.push_back(random_text_byte());
        end
      end else if (kind < 72) begin
        len = $urandom_range(0, 8);
        repeat (len) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        // around and past the line length limit
        len = $urandom_range(LINE_CHARS - 3, LINE_CHARS + 9);
        repeat (len) line_buf.push_back(random_text_byte());
      end else if (kind < 90) begin
        line_buf.push_back(menu_char());
        line_buf.push_back(CH_NUL);
        len = $urandom_range(0, 3);
        repeat (len) line_buf.push_back(random_text_byte());
      end else begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 90) line_buf.push_back(random_eol());
      foreach (line_buf[i]) begin
        send_byte(line_buf[i], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_result_backpressure();
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_request = 1'b1;
    repeat (20) begin
      send_byte(CH_FOUR, 1'b0, 1'b0, 1'b0);
      send_byte(CH_CR, 1'b0, 1'b0, 1'b0);
    end
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // result side: random stall before each transaction, or a long hold when asked
  initial begin
    int wait_cycles;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        wait_cycles = receiver_stalls_on ? $urandom_range(0, 11) : 0;
        if (wait_cycles > 0) begin
          res_stall <= 1'b1;
          repeat (wait_cycles) @(negedge clk);
        end
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (res_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // compare each result transaction with the oldest predicted event
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid === 1'b1 && !res_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result, event", 8'(res_item.event_res), 8'hff);
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        ev_seen[want.event_res] = 1'b1;
        if (res_item.event_res !== want.event_res)
          report_mismatch("event", 8'(res_item.event_res), 8'(want.event_res));
        if (res_item.position !== want.position)
          report_mismatch("position", res_item.position, want.position);
        if (res_item.ldo_level !== want.ldo_level)
          report_mismatch("ldo level", 8'(res_item.ldo_level), 8'(want.ldo_level));
        if (res_item.laser_level !== want.laser_level)
          report_mismatch("laser level", 8'(res_item.laser_level), 8'(want.laser_level));
        if (res_item.fan_level !== want.fan_level)
          report_mismatch("fan level", 8'(res_item.fan_level), 8'(want.fan_level));
      end
    end
  end

  // watchdog on cycles where neither channel moves a transaction
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, then the tests in turn, then drain and verdict
  initial begin
    int kinds;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_menu_commands();
    test_numeric_entry();
    test_random_traffic();
    test_result_backpressure();
    rx_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    kinds = 0;
    foreach (ev_seen[i]) kinds += ev_seen[i];
    $display("covered %0d input bytes and %0d result transactions", bytes_sent, events_checked);
    $display("%0d of 13 event kinds observed, %0d mismatches", kinds, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
